// ----- hw/rtl/bfct_pkg.sv -----
// Shared types and constants for the best-fit chunk table.
`default_nettype none

package bfct_pkg;

    // Fixed field widths on the streaming ports
    localparam int FIELD_BITS    = 32;
    localparam int SLOT_OUT_BITS = 6;
    localparam int STAMP_BITS    = 32;
    localparam int CMD_BITS      = 2;
    localparam int STATUS_BITS   = 2;

    // Slave-side packing
    localparam int S_TDATA_BITS = 104;
    localparam int S_TUSER_BITS = 3;
    localparam int IN_SIZE_LSB  = 0;
    localparam int IN_BASE_LSB  = 32;
    localparam int IN_ADDR_LSB  = 64;
    localparam int IN_SLOT_LSB  = 96;
    localparam int IN_LIST_BIT  = 2;

    // Master-side packing
    localparam int M_TDATA_BITS = 104;
    localparam int M_TUSER_BITS = 2;
    localparam int PAD_BITS     = M_TDATA_BITS - SLOT_OUT_BITS - 3 * FIELD_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_COMMIT,
        S_MARK_CHK,
        S_FINISH
    } state_t;

    // Verdict of the shared compare unit on one candidate record
    typedef struct packed {
        logic free;
        logic hit;
        logic better;
    } cmp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bfct_table.sv -----
// Record store: one write port, one registered read port.
`default_nettype none

module bfct_table
    import bfct_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int IDX_BITS  = 6,
    parameter int DATA_BITS = 162
)
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [IDX_BITS-1:0]  wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [IDX_BITS-1:0]  rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bfct_cmp.sv -----
// Shared compare unit: judges one record against the request and the best so far.
`default_nettype none

module bfct_cmp
    import bfct_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int ADDR_BITS = 32
)
(
    input  wire logic                  cand_valid,
    input  wire logic                  cand_in_used,
    input  wire logic [SIZE_BITS-1:0]  cand_size,
    input  wire logic [ADDR_BITS-1:0]  cand_addr,
    input  wire logic [STAMP_BITS-1:0] cand_stamp,
    input  wire logic                  req_list,
    input  wire logic [SIZE_BITS-1:0]  req_size,
    input  wire logic [ADDR_BITS-1:0]  req_addr,
    input  wire logic                  best_found,
    input  wire logic [SIZE_BITS-1:0]  best_size,
    input  wire logic [STAMP_BITS-1:0] best_stamp,
    output cmp_t                       verdict
);

    logic size_hit;
    logic addr_hit;

    always_comb
    begin
        size_hit = (req_size != '0) && (cand_size >= req_size);
        addr_hit = (req_addr != '0) && (cand_addr == req_addr);

        verdict.free   = !cand_valid;
        verdict.hit    = cand_valid && (cand_in_used == req_list) && (size_hit || addr_hit);
        // smaller size first; on equal size the newer stamp wins
        verdict.better = !best_found || (cand_size < best_size) ||
                         ((cand_size == best_size) && (cand_stamp > best_stamp));
    end

endmodule

`default_nettype wire

// ----- hw/rtl/best_fit_chunk_table.sv -----
// Top level of the best-fit chunk table: command sequencer around a record store.
//
// Usage
//   Commands arrive on the s_axis channel, one transfer per command; each command
//   yields exactly one result transfer on m_axis. tuser carries the command and list
//   on the way in and the status on the way out; tdata carries the payload.
//   Commands: add a record, mark a record onto a list (optionally resizing it), or
//   search a list for the first record, smallest size then newest, that fits or matches.
// Timing
//   Add and search walk every slot through the single read port of the store, one
//   slot a cycle, and then offer the result on m_axis. Mark reads only its own slot;
//   a rejected command skips the store and goes straight to its result.
//   One command is in flight at a time; s_axis_tready is high only while idle.
// Reset
//   After reset the block sweeps the store, one slot a cycle, clearing every valid
//   bit; s_axis_tready stays low until the sweep is done.
// Stalls
//   The result sits in an output register; the next command is taken while it waits.
//   If the receiver still holds off when a further result is ready, hold that result
//   in the sequencer until the output register frees up.
`default_nettype none

module best_fit_chunk_table
    import bfct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int SIZE_BITS     = 32,
    parameter int ADDR_BITS     = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // chunk_size[31:0], chunk_base[63:32], user_address[95:64], entry_slot[101:96], zero pad
    input  wire logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // command[1:0], target_list[2]
    input  wire logic [S_TUSER_BITS-1:0] s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // found_slot[5:0], found_size[37:6], found_base[69:38], found_address[101:70], zero pad
    output logic      [M_TDATA_BITS-1:0] m_axis_tdata,
    // result_status[1:0]
    output logic      [M_TUSER_BITS-1:0] m_axis_tuser
);

    localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);
    localparam int CNT_BITS  = SLOT_BITS + 1;
    localparam int REC_BITS  = 2 + STAMP_BITS + 2 * ADDR_BITS + SIZE_BITS;
    localparam int BASE_LSB  = SIZE_BITS;
    localparam int ADDR_LSB  = SIZE_BITS + ADDR_BITS;
    localparam int STAMP_LSB = SIZE_BITS + 2 * ADDR_BITS;

    // ---------------------------------------------------------------- state
    state_t                     state_reg, state_next;

    // latched command
    logic [CMD_BITS-1:0]        cmd_reg, cmd_next;
    logic                       list_reg, list_next;
    logic [SIZE_BITS-1:0]       size_reg, size_next;
    logic [ADDR_BITS-1:0]       base_reg, base_next;
    logic [ADDR_BITS-1:0]       addr_reg, addr_next;
    logic [SLOT_OUT_BITS-1:0]   slot_reg, slot_next;

    // scan sequencer (also walks the store during the clearing sweep)
    logic [CNT_BITS-1:0]        scan_idx_reg, scan_idx_next;
    logic                       pend_reg, pend_next;
    logic [SLOT_BITS-1:0]       pend_idx_reg, pend_idx_next;

    // best candidate so far
    logic                       best_found_reg, best_found_next;
    logic [SLOT_BITS-1:0]       best_slot_reg, best_slot_next;
    logic [SIZE_BITS-1:0]       best_size_reg, best_size_next;
    logic [ADDR_BITS-1:0]       best_base_reg, best_base_next;
    logic [ADDR_BITS-1:0]       best_addr_reg, best_addr_next;
    logic [STAMP_BITS-1:0]      best_stamp_reg, best_stamp_next;

    logic [STAMP_BITS-1:0]      stamp_cnt_reg, stamp_cnt_next;

    // finished result waiting for the output register
    status_t                    res_status_reg, res_status_next;
    logic [SLOT_OUT_BITS-1:0]   res_slot_reg, res_slot_next;
    logic [FIELD_BITS-1:0]      res_size_reg, res_size_next;
    logic [FIELD_BITS-1:0]      res_base_reg, res_base_next;
    logic [FIELD_BITS-1:0]      res_addr_reg, res_addr_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [M_TUSER_BITS-1:0]    out_user_reg, out_user_next;
    logic [M_TDATA_BITS-1:0]    out_data_reg, out_data_next;

    // ------------------------------------------------------------- datapath
    logic                       wr_en;
    logic [SLOT_BITS-1:0]       wr_addr;
    logic [REC_BITS-1:0]        wr_data;
    logic                       rd_en;
    logic [SLOT_BITS-1:0]       rd_addr;
    logic [REC_BITS-1:0]        rd_data;

    logic                       cand_valid;
    logic                       cand_in_used;
    logic [SIZE_BITS-1:0]       cand_size;
    logic [ADDR_BITS-1:0]       cand_base;
    logic [ADDR_BITS-1:0]       cand_addr;
    logic [STAMP_BITS-1:0]      cand_stamp;
    cmp_t                       verdict;

    logic                       scan_done;
    logic                       issue;
    logic                       arg_bad;
    logic                       out_free;
    logic [SIZE_BITS-1:0]       mark_size;

    bfct_table #(
        .DEPTH     (TABLE_ENTRIES),
        .IDX_BITS  (SLOT_BITS),
        .DATA_BITS (REC_BITS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // unpack the record read back from the store
    always_comb
    begin
        cand_size    = rd_data[SIZE_BITS-1:0];
        cand_base    = rd_data[BASE_LSB +: ADDR_BITS];
        cand_addr    = rd_data[ADDR_LSB +: ADDR_BITS];
        cand_stamp   = rd_data[STAMP_LSB +: STAMP_BITS];
        cand_in_used = rd_data[REC_BITS-2];
        cand_valid   = rd_data[REC_BITS-1];
    end

    bfct_cmp #(
        .SIZE_BITS (SIZE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_cmp (
        .cand_valid   (cand_valid),
        .cand_in_used (cand_in_used),
        .cand_size    (cand_size),
        .cand_addr    (cand_addr),
        .cand_stamp   (cand_stamp),
        .req_list     (list_reg),
        .req_size     (size_reg),
        .req_addr     (addr_reg),
        .best_found   (best_found_reg),
        .best_size    (best_size_reg),
        .best_stamp   (best_stamp_reg),
        .verdict      (verdict)
    );

    // ------------------------------------------------------ shared flags
    always_comb
    begin
        scan_done = (scan_idx_reg == CNT_BITS'(TABLE_ENTRIES));
        issue     = (state_reg == S_SCAN) && !scan_done;
        out_free  = !out_valid_reg || m_axis_tready;
        mark_size = (size_reg != '0) ? size_reg : cand_size;

        unique case (cmd_reg)
            CMD_ADD:    arg_bad = (size_reg == '0) || (base_reg == '0) || (addr_reg == '0);
            CMD_MARK:   arg_bad = (32'(slot_reg) >= 32'(TABLE_ENTRIES));
            CMD_SEARCH: arg_bad = (size_reg == '0) && (addr_reg == '0);
            default:    arg_bad = 1'b1;
        endcase
    end

    // ---------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (arg_bad)
                begin
                    state_next = S_FINISH;
                end
                else if (cmd_reg == CMD_MARK)
                begin
                    state_next = S_MARK_CHK;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue && !pend_reg)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:   state_next = S_FINISH;
            S_MARK_CHK: state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------ datapath
    always_comb
    begin
        cmd_next        = cmd_reg;
        list_next       = list_reg;
        size_next       = size_reg;
        base_next       = base_reg;
        addr_next       = addr_reg;
        slot_next       = slot_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = issue;
        pend_idx_next   = scan_idx_reg[SLOT_BITS-1:0];
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_size_next  = best_size_reg;
        best_base_next  = best_base_reg;
        best_addr_next  = best_addr_reg;
        best_stamp_next = best_stamp_reg;
        stamp_cnt_next  = stamp_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_size_next   = res_size_reg;
        res_base_next   = res_base_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_user_next   = out_user_reg;
        out_data_next   = out_data_reg;
        wr_en           = 1'b0;
        wr_addr         = scan_idx_reg[SLOT_BITS-1:0];
        wr_data         = '0;
        rd_en           = issue;
        rd_addr         = scan_idx_reg[SLOT_BITS-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // sweep the store, dropping every valid bit
                if (!scan_done)
                begin
                    wr_en         = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next  = s_axis_tuser[CMD_BITS-1:0];
                    list_next = s_axis_tuser[IN_LIST_BIT];
                    size_next = SIZE_BITS'(s_axis_tdata[IN_SIZE_LSB +: FIELD_BITS]);
                    base_next = ADDR_BITS'(s_axis_tdata[IN_BASE_LSB +: FIELD_BITS]);
                    addr_next = ADDR_BITS'(s_axis_tdata[IN_ADDR_LSB +: FIELD_BITS]);
                    slot_next = s_axis_tdata[IN_SLOT_LSB +: SLOT_OUT_BITS];
                end
            end
            S_DECODE:
            begin
                scan_idx_next   = '0;
                best_found_next = 1'b0;
                res_status_next = ST_INVALID;
                res_slot_next   = '0;
                res_size_next   = '0;
                res_base_next   = '0;
                res_addr_next   = '0;
                if (!arg_bad && (cmd_reg == CMD_MARK))
                begin
                    rd_en   = 1'b1;
                    rd_addr = SLOT_BITS'(slot_reg);
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        // keep the lowest free slot
                        if (verdict.free && !best_found_reg)
                        begin
                            best_found_next = 1'b1;
                            best_slot_next  = pend_idx_reg;
                        end
                    end
                    else if (verdict.hit && verdict.better)
                    begin
                        best_found_next = 1'b1;
                        best_slot_next  = pend_idx_reg;
                        best_size_next  = cand_size;
                        best_base_next  = cand_base;
                        best_addr_next  = cand_addr;
                        best_stamp_next = cand_stamp;
                    end
                end
            end
            S_COMMIT:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    if (best_found_reg)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = best_slot_reg;
                        wr_data         = {1'b1, list_reg, stamp_cnt_reg, addr_reg, base_reg,
                                           size_reg};
                        stamp_cnt_next  = stamp_cnt_reg + 1'b1;
                        res_status_next = ST_OK;
                        res_slot_next   = SLOT_OUT_BITS'(best_slot_reg);
                        res_size_next   = FIELD_BITS'(size_reg);
                        res_base_next   = FIELD_BITS'(base_reg);
                        res_addr_next   = FIELD_BITS'(addr_reg);
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                end
                else if (best_found_reg)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = SLOT_OUT_BITS'(best_slot_reg);
                    res_size_next   = FIELD_BITS'(best_size_reg);
                    res_base_next   = FIELD_BITS'(best_base_reg);
                    res_addr_next   = FIELD_BITS'(best_addr_reg);
                end
                else
                begin
                    res_status_next = ST_NOT_FOUND;
                end
            end
            S_MARK_CHK:
            begin
                // resize and restamp as newest of its size in a single write
                if (cand_valid)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = SLOT_BITS'(slot_reg);
                    wr_data         = {1'b1, list_reg, stamp_cnt_reg, cand_addr, cand_base,
                                       mark_size};
                    stamp_cnt_next  = stamp_cnt_reg + 1'b1;
                    res_status_next = ST_OK;
                    res_slot_next   = slot_reg;
                    res_size_next   = FIELD_BITS'(mark_size);
                    res_base_next   = FIELD_BITS'(cand_base);
                    res_addr_next   = FIELD_BITS'(cand_addr);
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = res_status_reg;
                    out_data_next  = {{PAD_BITS{1'b0}}, res_addr_reg, res_base_reg,
                                      res_size_reg, res_slot_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // ----------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            stamp_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
            cmd_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            best_found_reg <= best_found_next;
            stamp_cnt_reg  <= stamp_cnt_next;
            out_valid_reg  <= out_valid_next;
            cmd_reg        <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg       <= list_next;
        size_reg       <= size_next;
        base_reg       <= base_next;
        addr_reg       <= addr_next;
        slot_reg       <= slot_next;
        pend_idx_reg   <= pend_idx_next;
        best_slot_reg  <= best_slot_next;
        best_size_reg  <= best_size_next;
        best_base_reg  <= best_base_next;
        best_addr_reg  <= best_addr_next;
        best_stamp_reg <= best_stamp_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_size_reg   <= res_size_next;
        res_base_reg   <= res_base_next;
        res_addr_reg   <= res_addr_next;
        out_user_reg   <= out_user_next;
        out_data_reg   <= out_data_next;
    end

    // -------------------------------------------------------------- ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
